>>> hdl/owbm_pkg.sv
// Shared types and constants for the one-wire bus master.
package owbm_pkg;

  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 3;

  // Command codes
  localparam logic [1:0] CMD_NONE  = 2'd0;
  localparam logic [1:0] CMD_RESET = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_REC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_START   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_BIT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_REC     = 3'd6;

  // Register defaults
  localparam logic [CFG_W-1:0] DEF_RESET_LOW   = 10'd490;
  localparam logic [CFG_W-1:0] DEF_PRES_SAMPLE = 10'd100;
  localparam logic [CFG_W-1:0] DEF_RESET_REC   = 10'd480;
  localparam logic [CFG_W-1:0] DEF_SLOT_START  = 10'd2;
  localparam logic [CFG_W-1:0] DEF_WRITE_BIT   = 10'd45;
  localparam logic [CFG_W-1:0] DEF_READ_SAMPLE = 10'd4;
  localparam logic [CFG_W-1:0] DEF_READ_REC    = 10'd65;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] write_data;
    logic       bus_level;
  } owbm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence;
    logic [7:0] read_data;
  } owbm_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_ticks;
    logic [CFG_W-1:0] presence_sample_ticks;
    logic [CFG_W-1:0] reset_recovery_ticks;
    logic [CFG_W-1:0] slot_start_ticks;
    logic [CFG_W-1:0] write_bit_ticks;
    logic [CFG_W-1:0] read_sample_ticks;
    logic [CFG_W-1:0] read_recovery_ticks;
  } owbm_cfg_t;

endpackage

>>> hdl/owbm_cfg.sv
// Slot timing register file with write port.
module owbm_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owbm_pkg::CFG_W-1:0]      cfg_wdata,
  output owbm_pkg::owbm_cfg_t             cfg_o
);
  import owbm_pkg::*;

  owbm_cfg_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.reset_low_ticks       <= DEF_RESET_LOW;
      regs_r.presence_sample_ticks <= DEF_PRES_SAMPLE;
      regs_r.reset_recovery_ticks  <= DEF_RESET_REC;
      regs_r.slot_start_ticks      <= DEF_SLOT_START;
      regs_r.write_bit_ticks       <= DEF_WRITE_BIT;
      regs_r.read_sample_ticks     <= DEF_READ_SAMPLE;
      regs_r.read_recovery_ticks   <= DEF_READ_REC;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESET_LOW:   regs_r.reset_low_ticks       <= cfg_wdata;
        REG_PRES_SAMPLE: regs_r.presence_sample_ticks <= cfg_wdata;
        REG_RESET_REC:   regs_r.reset_recovery_ticks  <= cfg_wdata;
        REG_SLOT_START:  regs_r.slot_start_ticks      <= cfg_wdata;
        REG_WRITE_BIT:   regs_r.write_bit_ticks       <= cfg_wdata;
        REG_READ_SAMPLE: regs_r.read_sample_ticks     <= cfg_wdata;
        REG_READ_REC:    regs_r.read_recovery_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = regs_r;

endmodule

>>> hdl/owbm_seq.sv
// Slot sequencer: phase state, tick timer, shift byte and result register.
module owbm_seq #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  owbm_pkg::owbm_cfg_t  cfg_i,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  owbm_pkg::owbm_in_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output owbm_pkg::owbm_out_t  out_data
);
  import owbm_pkg::*;

  localparam int CMP_W = (TICK_COUNT_BITS + 1 > CFG_W) ? TICK_COUNT_BITS + 1 : CFG_W;
  localparam logic [TICK_COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_REC  = 4'd3,
    PH_WR_START = 4'd4,
    PH_WR_BIT   = 4'd5,
    PH_RD_START = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_REC   = 4'd8
  } phase_t;

  phase_t                     phase_r, phase_nxt;
  logic [TICK_COUNT_BITS-1:0] tick_r, tick_nxt;
  logic [2:0]                 bit_r, bit_nxt;
  logic [7:0]                 shift_r, shift_nxt;
  logic                       pres_r, pres_nxt;
  logic [7:0]                 held_r, held_nxt;
  owbm_out_t                  out_data_r, res_nxt;
  logic                       out_valid_r;
  logic                       accept;

  // Working values after a possible command start
  phase_t                     ph_w;
  logic [TICK_COUNT_BITS-1:0] tick_w;
  logic [2:0]                 bit_w, bit_inc;
  logic [7:0]                 shift_w;
  logic [CFG_W-1:0]           len_w;
  logic [CMP_W-1:0]           n_w;
  logic                       ends, drive, done;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    ph_w    = phase_r;
    tick_w  = tick_r;
    bit_w   = bit_r;
    shift_w = shift_r;
    if (phase_r == PH_IDLE && in_data.command != CMD_NONE) begin
      tick_w = '0;
      bit_w  = '0;
      case (in_data.command)
        CMD_RESET: ph_w = PH_RST_LOW;
        CMD_WRITE: begin
          ph_w    = PH_WR_START;
          shift_w = in_data.write_data;
        end
        default: begin
          ph_w    = PH_RD_START;
          shift_w = '0;
        end
      endcase
    end

    case (ph_w)
      PH_RST_LOW:                len_w = cfg_i.reset_low_ticks;
      PH_RST_WAIT:               len_w = cfg_i.presence_sample_ticks;
      PH_RST_REC:                len_w = cfg_i.reset_recovery_ticks;
      PH_WR_START, PH_RD_START:  len_w = cfg_i.slot_start_ticks;
      PH_WR_BIT:                 len_w = cfg_i.write_bit_ticks;
      PH_RD_WAIT:                len_w = cfg_i.read_sample_ticks;
      PH_RD_REC:                 len_w = cfg_i.read_recovery_ticks;
      default:                   len_w = '0;
    endcase

    n_w     = CMP_W'(tick_w) + CMP_W'(1);
    ends    = (n_w >= CMP_W'(len_w)) || (n_w >= CMP_W'(CNT_MAX));
    bit_inc = bit_w + 3'd1;

    phase_nxt = ph_w;
    tick_nxt  = tick_w;
    bit_nxt   = bit_w;
    shift_nxt = shift_w;
    pres_nxt  = pres_r;
    held_nxt  = held_r;
    drive     = 1'b0;
    done      = 1'b0;

    if (ph_w != PH_IDLE) begin
      case (ph_w)
        PH_RST_LOW, PH_WR_START, PH_RD_START: drive = 1'b1;
        PH_WR_BIT:                            drive = ~shift_w[0];
        default:                              drive = 1'b0;
      endcase

      if (!ends) begin
        tick_nxt = n_w[TICK_COUNT_BITS-1:0];
      end else begin
        tick_nxt = '0;
        case (ph_w)
          PH_RST_LOW:  phase_nxt = PH_RST_WAIT;
          PH_RST_WAIT: begin
            pres_nxt  = ~in_data.bus_level;
            phase_nxt = PH_RST_REC;
          end
          PH_RST_REC: begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end
          PH_WR_START: phase_nxt = PH_WR_BIT;
          PH_WR_BIT: begin
            shift_nxt = {1'b0, shift_w[7:1]};
            bit_nxt   = bit_inc;
            if (bit_inc == 3'd0) begin
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_WR_START;
            end
          end
          PH_RD_START: phase_nxt = PH_RD_WAIT;
          PH_RD_WAIT: begin
            // shift the sampled bit in from the top, LSB ends up first
            shift_nxt = {in_data.bus_level, shift_w[7:1]};
            phase_nxt = PH_RD_REC;
          end
          PH_RD_REC: begin
            bit_nxt = bit_inc;
            if (bit_inc == 3'd0) begin
              held_nxt  = shift_w;
              phase_nxt = PH_IDLE;
              done      = 1'b1;
            end else begin
              phase_nxt = PH_RD_START;
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
            drive     = 1'b0;
          end
        endcase
      end
    end

    res_nxt.drive_low = drive;
    res_nxt.busy_res  = (phase_nxt != PH_IDLE);
    res_nxt.done_res  = done;
    res_nxt.presence  = pres_nxt;
    res_nxt.read_data = held_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        bit_r       <= bit_nxt;
        shift_r     <= shift_nxt;
        pres_r      <= pres_nxt;
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        // drop the beat once taken
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/one_wire_bus_master_unit.sv
// Top level of the one-wire bus master: config registers and slot sequencer.
//
//   Channel  Direction  Handshake            Beat contents
//   in_      input      in_valid / in_stall  command, write_data, bus_level (one tick)
//   out_     output     out_valid / out_stall drive_low, busy_res, done_res, presence,
//                                            read_data
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// One result beat per input beat, valid in the cycle after acceptance; a new tick
// can be accepted every cycle while in_stall is low. One result register holds each beat.
// Synchronous active-low reset restores the register defaults and idles the bus.
// in_stall rises only while a result beat is held under out_stall.
module one_wire_bus_master_unit #(
  parameter int TICK_COUNT_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  owbm_pkg::owbm_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output owbm_pkg::owbm_out_t             out_data,
  input  logic                            cfg_we,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [owbm_pkg::CFG_W-1:0]      cfg_wdata
);
  import owbm_pkg::*;

  owbm_cfg_t cfg;

  owbm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  owbm_seq #(
    .TICK_COUNT_BITS (TICK_COUNT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_i     (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
